FILE: design/spq_pkg.sv
// spq_pkg: shared types and constants for the stable priority queue
// entry layout, result status codes and default queue depth
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int OCC_W = 5;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  sev;
    logic [15:0] arr;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   srv;
    entry_t ent;
  } cmd_t;

  localparam logic [1:0] ST_INSERTED   = 2'd0;
  localparam logic [1:0] ST_SERVED     = 2'd1;
  localparam logic [1:0] ST_SERVE_EMPTY = 2'd2;
  localparam logic [1:0] ST_INS_FULL   = 2'd3;

endpackage

FILE: design/spq_if.sv
// spq_in_if / spq_out_if: valid/ready channels of the priority queue
// request beats carry mode and entry, result beats carry status and served entry
// no dependencies
`timescale 1ns / 1ps

interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] item_id;
  logic [7:0]  severity;
  logic [15:0] arrival_number;

  modport source (output valid, mode, item_id, severity, arrival_number, input ready);
  modport sink (input valid, mode, item_id, severity, arrival_number, output ready);
endinterface

interface spq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [7:0]  out_severity;
  logic [15:0] out_arrival;
  logic [4:0]  occupancy;

  modport source (output valid, status, out_id, out_severity, out_arrival, occupancy,
                  input ready);
  modport sink (input valid, status, out_id, out_severity, out_arrival, occupancy,
                output ready);
endinterface

FILE: design/stable_priority_queue.sv
// stable_priority_queue: bounded priority queue built as a chain of sorting cells
// lower severity first, ties by lower arrival number, equal keys in arrival order
// depends on spq_pkg, spq_if, spq_cell
//
//  channel | dir | beat contents
//  in_ch   | in  | mode, item_id, severity, arrival_number
//  out_ch  | out | status, out_id, out_severity, out_arrival, occupancy
//
// one request beat per cycle while ready; result is registered the next cycle
// every cell compares with the broadcast key and shifts in the same cycle
// in_ch.ready is high while the result register is empty or being drained
// reset clears the count and result valid only; slots above the count are never read
`timescale 1ns / 1ps

module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             empty;
  logic             in_acc;
  cmd_t             cmd;
  entry_t           ents [QUEUE_DEPTH];
  logic             afters [QUEUE_DEPTH];
  logic [1:0]       status_nxt;
  entry_t           res_nxt;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  logic             out_valid_r;
  logic [1:0]       status_r;
  entry_t           res_r;
  logic [OCC_W-1:0] occ_r;

  assign full   = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty  = count_r == '0;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign cmd.ins     = in_acc && !in_ch.mode && !full;
  assign cmd.srv     = in_acc && in_ch.mode && !empty;
  assign cmd.ent.id  = in_ch.item_id;
  assign cmd.ent.sev = in_ch.severity;
  assign cmd.ent.arr = in_ch.arrival_number;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t left_e;
      logic   left_a;
      entry_t right_e;
      if (g == 0) begin : g_head
        assign left_e = cmd.ent;
        assign left_a = 1'b0;
      end else begin : g_mid
        assign left_e = ents[g-1];
        assign left_a = afters[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = ents[g];
      end else begin : g_inner
        assign right_e = ents[g+1];
      end
      spq_cell #(
        .IDX   (g),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .count      (count_r),
        .left_ent   (left_e),
        .left_after (left_a),
        .right_ent  (right_e),
        .ent        (ents[g]),
        .after      (afters[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    res_nxt    = '0;
    status_nxt = ST_INSERTED;
    if (!in_ch.mode) begin
      if (full) begin
        status_nxt = ST_INS_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_SERVE_EMPTY;
      end else begin
        status_nxt = ST_SERVED;
        res_nxt    = ents[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_id       = res_r.id;
  assign out_ch.out_severity = res_r.sev;
  assign out_ch.out_arrival  = res_r.arr;
  assign out_ch.occupancy    = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("count above queue depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.mode && !full) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow count");

  a_empty_serve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode && empty) |=> out_valid_r && status_r == ST_SERVE_EMPTY)
    else $error("serve on empty not flagged");

  a_served_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_SERVED && !empty) |->
      {res_r.sev, res_r.arr} <= {ents[0].sev, ents[0].arr})
    else $error("served entry ranks after new head");

endmodule

FILE: design/spq_cell.sv
// spq_cell: one slot of the sorted shift chain
// compares its entry against the broadcast key and shifts left or right
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic           clk,
  input  spq_pkg::cmd_t  cmd,
  input  logic [CNT_W-1:0] count,
  input  spq_pkg::entry_t left_ent,
  input  logic           left_after,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output logic           after
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   occ;
  logic   take;

  assign occ   = count > CNT_W'(IDX);
  assign after = occ && ({ent_r.sev, ent_r.arr} > {cmd.ent.sev, cmd.ent.arr});
  assign take  = after || (count == CNT_W'(IDX));
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && take) begin
      ent_nxt = left_after ? left_ent : cmd.ent;
    end else if (cmd.srv) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
